@@ sv/path_rule_wildcard_matcher_macros.svh @@
// Assertion macros shared by the path rule matcher.
// No dependencies; included by the top level that carries the checks.
`ifndef PATH_RULE_WILDCARD_MATCHER_MACROS_SVH
`define PATH_RULE_WILDCARD_MATCHER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRWM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("path rule matcher check failed");

// The consequent must hold in the cycle after the antecedent.
`define PRWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("path rule matcher check failed");

`endif

@@ sv/prwm_pkg.sv @@
// Shared types and constants of the path rule matcher.
// No dependencies; used by every module of the block.
package prwm_pkg;

    localparam int MODE_W = 2;
    localparam int SLOT_W = 3;
    localparam int KIND_W = 2;
    localparam int LEN_W  = 6;
    localparam int POS_W  = 5;
    localparam int CHAR_W = 8;

    localparam int NUM_RULES_DEF = 8;
    localparam int PAT_LEN_DEF   = 32;

    localparam logic [MODE_W-1:0] MODE_HDR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CHR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PATH = 2'd2;
    localparam logic [MODE_W-1:0] MODE_END  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_UNUSED   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOW    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DISALLOW = 2'd2;

    localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;

    // Per-rule commands decoded from the item in the input register.
    typedef struct packed {
        logic hdr_we;
        logic chr_we;
        logic step;
        logic rearm;
    } rule_cmd_t;

    // Per-rule standing at end of path.
    typedef struct packed {
        logic             hit;
        logic             allow;
        logic [LEN_W-1:0] len;
    } rule_stat_t;

endpackage

@@ sv/prwm_rule.sv @@
// One rule of the matcher: header, pattern bytes and its position-set automaton.
// Depends on prwm_pkg.
module prwm_rule
    import prwm_pkg::*;
#(
    parameter int PAT_LEN = PAT_LEN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  rule_cmd_t         cmd,
    input  logic [KIND_W-1:0] kind,
    input  logic [LEN_W-1:0]  length,
    input  logic [POS_W-1:0]  pos,
    input  logic [CHAR_W-1:0] ch,
    output rule_stat_t        stat
);

    logic [KIND_W-1:0] kind_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic [CHAR_W-1:0] pat_reg [PAT_LEN];
    logic [PAT_LEN:0]  act_reg;
    logic [PAT_LEN:0]  act_next;
    logic              pfx_reg;
    logic              pfx_next;

    logic [PAT_LEN-1:0] thermo;
    logic [PAT_LEN-1:0] last;
    logic [PAT_LEN-1:0] star;
    logic [PAT_LEN-1:0] dollar;
    logic [PAT_LEN-1:0] eq;
    logic [PAT_LEN-1:0] body;
    logic [PAT_LEN-1:0] adv;
    logic [PAT_LEN:0]   tail;
    logic [PAT_LEN:0]   endpos;
    logic [PAT_LEN:0]   prop;
    logic [PAT_LEN:0]   gen;
    logic [PAT_LEN:0]   closed;
    logic               anch;
    logic               at_end;
    logic               in_use;

    assign len_next = (int'(length) > PAT_LEN) ? LEN_W'(PAT_LEN) : length;

    always_comb
    begin
        for (int i = 0; i < PAT_LEN; i++)
        begin
            thermo[i] = i < int'(len_reg);
            last[i]   = (i + 1) == int'(len_reg);
            star[i]   = pat_reg[i] == CH_STAR;
            dollar[i] = pat_reg[i] == CH_DOLLAR;
            eq[i]     = pat_reg[i] == ch;
        end
        for (int i = 0; i <= PAT_LEN; i++)
        begin
            tail[i] = i == int'(len_reg);
        end
    end

    // A trailing '$' anchors the pattern and is not part of its body.
    assign anch   = |(last & dollar);
    assign body   = anch ? (thermo & ~last) : thermo;
    assign endpos = anch ? {1'b0, last} : tail;

    // Star closure as a carry chain: a reached star position carries through
    // the run of stars that follows it.
    assign prop   = {1'b0, star & body};
    assign gen    = act_reg & prop;
    assign closed = act_reg | ((prop + gen) ^ prop ^ gen);
    assign at_end = |(closed & endpos);

    assign adv      = closed[PAT_LEN-1:0] & body & ~star & eq;
    assign act_next = {adv, 1'b0} | {1'b0, closed[PAT_LEN-1:0] & body & star};
    assign pfx_next = pfx_reg | at_end;

    assign in_use     = ((kind_reg == KIND_ALLOW) || (kind_reg == KIND_DISALLOW))
                        && (len_reg != '0);
    assign stat.hit   = in_use && (at_end || (!anch && pfx_reg));
    assign stat.allow = kind_reg == KIND_ALLOW;
    assign stat.len   = len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_UNUSED;
            len_reg  <= '0;
            act_reg  <= (PAT_LEN + 1)'(1);
            pfx_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.hdr_we)
            begin
                kind_reg <= kind;
                len_reg  <= len_next;
            end
            if (cmd.rearm)
            begin
                act_reg <= (PAT_LEN + 1)'(1);
                pfx_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                act_reg <= act_next;
                pfx_reg <= pfx_next;
            end
        end
    end

    // Pattern bytes carry no reset; the user must have a byte written before it is read; the block does not check.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PAT_LEN; i++)
        begin
            if (cmd.chr_we && (int'(pos) == i))
            begin
                pat_reg[i] <= ch;
            end
        end
    end

endmodule

@@ sv/prwm_verdict.sv @@
// Verdict logic: longest matching rule wins, Allow wins a tie.
// Depends on prwm_pkg.
module prwm_verdict
    import prwm_pkg::*;
#(
    parameter int NUM_RULES = NUM_RULES_DEF
)
(
    input  rule_stat_t       stat [NUM_RULES],
    output logic             forbidden,
    output logic             any_match,
    output logic [LEN_W-1:0] best_length
);

    logic [LEN_W-1:0] best;
    logic             found;
    logic             allow_at_best;

    always_comb
    begin
        best  = '0;
        found = 1'b0;
        for (int r = 0; r < NUM_RULES; r++)
        begin
            if (stat[r].hit && (stat[r].len > best))
            begin
                best = stat[r].len;
            end
            found = found | stat[r].hit;
        end
        allow_at_best = 1'b0;
        for (int r = 0; r < NUM_RULES; r++)
        begin
            if (stat[r].hit && stat[r].allow && (stat[r].len == best))
            begin
                allow_at_best = 1'b1;
            end
        end
    end

    // Active rules have nonzero length, so best is zero when nothing matched.
    assign forbidden   = found && !allow_at_best;
    assign any_match   = found;
    assign best_length = best;

endmodule

@@ sv/path_rule_wildcard_matcher.sv @@
// Top level of the path rule matcher: input register, rule array, result register.
// Depends on prwm_pkg, prwm_rule, prwm_verdict and the assertion macro header.
//
// The block takes one item per cycle in every mode. An accepted item sits in
// the input register while all rules update their position sets in parallel
// (one short carry chain per rule closes runs of '*'); an end of path item
// writes its verdict into the result register as it leaves the input
// register, and the result port is driven from that register. The input side
// stalls only while an end of path item waits behind a verdict that has not
// been taken.
// Table writes and path bytes give no result.
`include "path_rule_wildcard_matcher_macros.svh"

module path_rule_wildcard_matcher
    import prwm_pkg::*;
#(
    parameter int NUM_RULES = NUM_RULES_DEF,
    parameter int PAT_LEN   = PAT_LEN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [MODE_W-1:0] mode,
    input  logic [SLOT_W-1:0] rule_slot,
    input  logic [KIND_W-1:0] rule_kind,
    input  logic [LEN_W-1:0]  rule_length,
    input  logic [POS_W-1:0]  char_position,
    input  logic [CHAR_W-1:0] char_value,
    output logic              result_valid,
    input  logic              result_stall,
    output logic              forbidden,
    output logic              any_match,
    output logic [LEN_W-1:0]  best_length
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [MODE_W-1:0] s1_mode_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic [KIND_W-1:0] s1_kind_reg;
    logic [LEN_W-1:0]  s1_len_reg;
    logic [POS_W-1:0]  s1_pos_reg;
    logic [CHAR_W-1:0] s1_char_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              forbidden_reg;
    logic              any_match_reg;
    logic [LEN_W-1:0]  best_reg;

    logic              in_take;
    logic              s1_go;
    logic              s1_end;
    logic              v_forbidden;
    logic              v_any;
    logic [LEN_W-1:0]  v_best;

    rule_cmd_t  cmd  [NUM_RULES];
    rule_stat_t stat [NUM_RULES];

    assign s1_end     = s1_mode_reg == MODE_END;
    assign s1_go      = s1_valid_reg && (!s1_end || !out_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !s1_go;
    assign in_take    = item_valid && !item_stall;

    assign s1_valid_next  = in_take || (s1_valid_reg && !s1_go);
    assign out_valid_next = (s1_go && s1_end) || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_mode_reg <= mode;
            s1_slot_reg <= rule_slot;
            s1_kind_reg <= rule_kind;
            s1_len_reg  <= rule_length;
            s1_pos_reg  <= char_position;
            s1_char_reg <= char_value;
        end
        if (s1_go && s1_end)
        begin
            forbidden_reg <= v_forbidden;
            any_match_reg <= v_any;
            best_reg      <= v_best;
        end
    end

    generate
        for (genvar r = 0; r < NUM_RULES; r++)
        begin : g_rule
            always_comb
            begin
                cmd[r].hdr_we = s1_go && (s1_mode_reg == MODE_HDR)
                                && (int'(s1_slot_reg) == r);
                cmd[r].chr_we = s1_go && (s1_mode_reg == MODE_CHR)
                                && (int'(s1_slot_reg) == r)
                                && (int'(s1_pos_reg) < PAT_LEN);
                cmd[r].step   = s1_go && (s1_mode_reg == MODE_PATH);
                cmd[r].rearm  = s1_go && s1_end;
            end

            prwm_rule #(
                .PAT_LEN (PAT_LEN)
            ) u_rule (
                .clk    (clk),
                .rst_n  (rst_n),
                .cmd    (cmd[r]),
                .kind   (s1_kind_reg),
                .length (s1_len_reg),
                .pos    (s1_pos_reg),
                .ch     (s1_char_reg),
                .stat   (stat[r])
            );
        end
    endgenerate

    prwm_verdict #(
        .NUM_RULES (NUM_RULES)
    ) u_verdict (
        .stat        (stat),
        .forbidden   (v_forbidden),
        .any_match   (v_any),
        .best_length (v_best)
    );

    assign result_valid = out_valid_reg;
    assign forbidden    = forbidden_reg;
    assign any_match    = any_match_reg;
    assign best_length  = best_reg;

    // An end of path item must wait while the verdict ahead of it is held.
    `PRWM_ASSERT_NOW(a_end_waits, clk, rst_n, s1_valid_reg && s1_end && out_valid_reg && result_stall, item_stall)
    // Every end of path item that leaves the input register yields a verdict.
    `PRWM_ASSERT_NEXT(a_end_gives_result, clk, rst_n, s1_go && s1_end, out_valid_reg)
    // A verdict with no match reports an allowed path of length zero.
    `PRWM_ASSERT_NOW(a_no_match_clean, clk, rst_n, out_valid_reg && !any_match_reg, (best_reg == '0) && !forbidden_reg)
    // A match always names a nonzero winning length.
    `PRWM_ASSERT_NOW(a_match_has_len, clk, rst_n, out_valid_reg && any_match_reg, best_reg != '0)

endmodule

@@ tb/sv/path_verdict_monitor.sv @@
`timescale 1ns / 100ps
// Checker for the path rule matcher: watches both channels, keeps its own copy of the
// rule table and of the per-rule position sets, and compares every verdict item.
// Depends on prwm_pkg for field widths, mode and kind codes and the pattern characters.
module path_verdict_monitor
    import prwm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  logic [MODE_W-1:0] mode,
    input  logic [SLOT_W-1:0] rule_slot,
    input  logic [KIND_W-1:0] rule_kind,
    input  logic [LEN_W-1:0]  rule_length,
    input  logic [POS_W-1:0]  char_position,
    input  logic [CHAR_W-1:0] char_value,
    input  logic              result_valid,
    input  logic              result_stall,
    input  logic              forbidden,
    input  logic              any_match,
    input  logic [LEN_W-1:0]  best_length,
    output int                fail_count,
    output int                open_count
);

    localparam int RULES = NUM_RULES_DEF;
    localparam int PLEN  = PAT_LEN_DEF;

    typedef struct packed {
        logic             forbidden;
        logic             any_match;
        logic [LEN_W-1:0] best_length;
    } verdict_t;

    logic [CHAR_W-1:0] pat_mem [RULES][PLEN];
    logic [KIND_W-1:0] kind_tab [RULES];
    logic [LEN_W-1:0]  len_tab [RULES];
    logic [PLEN:0]     reach [RULES];
    logic              prefix_seen [RULES];
    verdict_t          expected_verdicts [$];
    int                mismatches;

    // A last byte of '$' anchors the pattern and is not part of the body.
    function automatic int body_len(input int r, output bit anchored);
        int n;
        n = len_tab[r];
        anchored = 1'b0;
        if (n > 0 && pat_mem[r][n-1] == CH_DOLLAR)
        begin
            anchored = 1'b1;
            n = n - 1;
        end
        return n;
    endfunction

    // A reached '*' also reaches the following position, so runs of stars chain.
    function automatic logic [PLEN:0] closed_reach(input int r, input int body);
        logic [PLEN:0] s;
        s = reach[r];
        for (int i = 0; i < body; i++)
            if (s[i] && pat_mem[r][i] == CH_STAR)
                s[i+1] = 1'b1;
        return s;
    endfunction

    function automatic void rearm_all();
        for (int r = 0; r < RULES; r++)
        begin
            reach[r] = 1;
            prefix_seen[r] = 1'b0;
        end
    endfunction

    function automatic void advance_automata(input logic [CHAR_W-1:0] ch);
        int            m;
        bit            anch;
        logic [PLEN:0] s;
        logic [PLEN:0] nxt;
        for (int r = 0; r < RULES; r++)
        begin
            m = body_len(r, anch);
            s = closed_reach(r, m);
            if (s[m])
                prefix_seen[r] = 1'b1;
            nxt = '0;
            for (int i = 0; i < m; i++)
            begin
                if (s[i])
                begin
                    if (pat_mem[r][i] == CH_STAR)
                        nxt[i] = 1'b1;
                    else if (pat_mem[r][i] == ch)
                        nxt[i+1] = 1'b1;
                end
            end
            reach[r] = nxt;
        end
    endfunction

    function automatic verdict_t judge_path();
        verdict_t      v;
        int            best;
        int            m;
        bit            found;
        bit            best_allow;
        bit            anch;
        bit            hit;
        logic [PLEN:0] s;
        best = 0;
        found = 1'b0;
        best_allow = 1'b0;
        for (int r = 0; r < RULES; r++)
        begin
            if (!((kind_tab[r] == KIND_ALLOW || kind_tab[r] == KIND_DISALLOW) && len_tab[r] != 0))
                continue;
            m = body_len(r, anch);
            s = closed_reach(r, m);
            hit = s[m];
            if (!anch && prefix_seen[r])
                hit = 1'b1;
            if (!hit)
                continue;
            if (!found || len_tab[r] > best || (len_tab[r] == best && kind_tab[r] == KIND_ALLOW))
            begin
                best = len_tab[r];
                best_allow = (kind_tab[r] == KIND_ALLOW);
                found = 1'b1;
            end
        end
        v.forbidden = found && !best_allow;
        v.any_match = found;
        v.best_length = found ? LEN_W'(best) : '0;
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        verdict_t want;
        if (!rst_n)
        begin
            for (int r = 0; r < RULES; r++)
            begin
                kind_tab[r] = KIND_UNUSED;
                len_tab[r] = '0;
                for (int p = 0; p < PLEN; p++)
                    pat_mem[r][p] = '0;
            end
            rearm_all();
            expected_verdicts.delete();
            mismatches = 0;
            fail_count <= 0;
            open_count <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: verdict item with none outstanding: forbidden %0b any_match %0b best_length %0d",
                             $time, forbidden, any_match, best_length);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (forbidden !== want.forbidden)
                    begin
                        mismatches++;
                        $display("%0t: forbidden expected %0b, got %0b",
                                 $time, want.forbidden, forbidden);
                    end
                    if (any_match !== want.any_match)
                    begin
                        mismatches++;
                        $display("%0t: any_match expected %0b, got %0b",
                                 $time, want.any_match, any_match);
                    end
                    if (best_length !== want.best_length)
                    begin
                        mismatches++;
                        $display("%0t: best_length expected %0d, got %0d",
                                 $time, want.best_length, best_length);
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                case (mode)
                    MODE_HDR:
                    begin
                        kind_tab[rule_slot] = rule_kind;
                        len_tab[rule_slot] = (rule_length > LEN_W'(PLEN)) ? LEN_W'(PLEN)
                                                                         : rule_length;
                    end
                    MODE_CHR:
                        pat_mem[rule_slot][char_position] = char_value;
                    MODE_PATH:
                        advance_automata(char_value);
                    MODE_END:
                    begin
                        expected_verdicts.push_back(judge_path());
                        rearm_all();
                    end
                    default:
                        ;
                endcase
            end
            fail_count <= mismatches;
            open_count <= expected_verdicts.size();
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// Top of the path rule matcher testbench: clock, reset, stimulus and the verdict.
// Depends on prwm_pkg, the matcher itself and the path_verdict_monitor checker.
module testbench;
    import prwm_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    logic [MODE_W-1:0] mode = '0;
    logic [SLOT_W-1:0] rule_slot = '0;
    logic [KIND_W-1:0] rule_kind = '0;
    logic [LEN_W-1:0]  rule_length = '0;
    logic [POS_W-1:0]  char_position = '0;
    logic [CHAR_W-1:0] char_value = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic              forbidden;
    logic              any_match;
    logic [LEN_W-1:0]  best_length;
    int                fail_count;
    int                open_count;

    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;

    // Shadow of the table as written, used to build paths that reach deep and to fill unwritten bytes.
    bit [CHAR_W-1:0]      shadow_pat [NUM_RULES_DEF][PAT_LEN_DEF];
    bit [PAT_LEN_DEF-1:0] written_mask [NUM_RULES_DEF];
    int                   shadow_len [NUM_RULES_DEF];

    path_rule_wildcard_matcher u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .mode          (mode),
        .rule_slot     (rule_slot),
        .rule_kind     (rule_kind),
        .rule_length   (rule_length),
        .char_position (char_position),
        .char_value    (char_value),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .forbidden     (forbidden),
        .any_match     (any_match),
        .best_length   (best_length)
    );

    path_verdict_monitor u_monitor
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .mode          (mode),
        .rule_slot     (rule_slot),
        .rule_kind     (rule_kind),
        .rule_length   (rule_length),
        .char_position (char_position),
        .char_value    (char_value),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .forbidden     (forbidden),
        .any_match     (any_match),
        .best_length   (best_length),
        .fail_count    (fail_count),
        .open_count    (open_count)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    task automatic send_item(input logic [MODE_W-1:0] m, input logic [SLOT_W-1:0] s,
                             input logic [KIND_W-1:0] k, input logic [LEN_W-1:0] l,
                             input logic [POS_W-1:0] p, input logic [CHAR_W-1:0] c);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        mode <= m;
        rule_slot <= s;
        rule_kind <= k;
        rule_length <= l;
        char_position <= p;
        char_value <= c;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Holds the sender off until every outstanding verdict has been taken.
    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (open_count != 0)
            @(posedge clk);
    endtask

    function automatic logic [CHAR_W-1:0] path_char();
        string alpha;
        alpha = "/ab.";
        if ($urandom_range(9) == 0)
            return CHAR_W'($urandom_range(255));
        return alpha[$urandom_range(3)];
    endfunction

    function automatic logic [CHAR_W-1:0] pattern_char();
        int roll;
        roll = $urandom_range(99);
        if (roll < 20)
            return CH_STAR;
        if (roll < 24)
            return CH_DOLLAR;
        return path_char();
    endfunction

    task automatic put_byte(input int slot, input int pos, input logic [CHAR_W-1:0] val);
        send_item(MODE_CHR, SLOT_W'(slot), KIND_W'($urandom), LEN_W'($urandom),
                  POS_W'(pos), val);
        shadow_pat[slot][pos] = val;
        written_mask[slot][pos] = 1'b1;
    endtask

    // Every byte that the new length covers must have been written before the
    // matcher reads it, so missing bytes are filled first.
    task automatic put_header(input int slot, input int kind, input int len);
        int cover_n;
        cover_n = (len > PAT_LEN_DEF) ? PAT_LEN_DEF : len;
        for (int p = 0; p < cover_n; p++)
            if (!written_mask[slot][p])
                put_byte(slot, p, pattern_char());
        send_item(MODE_HDR, SLOT_W'(slot), KIND_W'(kind), LEN_W'(len),
                  POS_W'($urandom), CHAR_W'($urandom));
        shadow_len[slot] = cover_n;
    endtask

    task automatic program_rule(input int slot);
        int n;
        int hdr_len;
        int kind;
        if ($urandom_range(9) == 0)
            n = $urandom_range(1) ? PAT_LEN_DEF : $urandom_range(9, PAT_LEN_DEF - 1);
        else
            n = $urandom_range(1, 8);
        for (int p = 0; p < n; p++)
            put_byte(slot, p, (p == n - 1 && $urandom_range(9) < 4) ? CH_DOLLAR : pattern_char());
        hdr_len = n;
        if (n == PAT_LEN_DEF && $urandom_range(1))
            hdr_len = $urandom_range(PAT_LEN_DEF + 1, 63);
        kind = ($urandom_range(9) == 0) ? $urandom_range(3) : $urandom_range(1, 2);
        put_header(slot, kind, hdr_len);
    endtask

    task automatic table_noise();
        if ($urandom_range(1))
            put_byte($urandom_range(NUM_RULES_DEF - 1), $urandom_range(PAT_LEN_DEF - 1),
                     pattern_char());
        else
            put_header($urandom_range(NUM_RULES_DEF - 1), $urandom_range(3),
                       $urandom_range(1) ? 0 : $urandom_range(63));
    endtask

    task automatic feed_byte(input logic [CHAR_W-1:0] ch);
        send_item(MODE_PATH, SLOT_W'($urandom), KIND_W'($urandom), LEN_W'($urandom),
                  POS_W'($urandom), ch);
    endtask

    // Path bytes in the random part now and then have a table write slipped in.
    task automatic path_byte(input logic [CHAR_W-1:0] ch);
        if ($urandom_range(49) == 0)
            table_noise();
        feed_byte(ch);
    endtask

    task automatic end_path();
        send_item(MODE_END, SLOT_W'($urandom), KIND_W'($urandom), LEN_W'($urandom),
                  POS_W'($urandom), CHAR_W'($urandom));
    endtask

    // Streams a path built from one rule's pattern, with stars expanded and
    // occasional damage so that near misses are common too.
    task automatic walk_path(input int slot);
        int               n;
        int               emitted;
        logic [CHAR_W-1:0] b;
        n = shadow_len[slot];
        emitted = 0;
        for (int i = 0; i < n && emitted < 48; i++)
        begin
            b = shadow_pat[slot][i];
            if ($urandom_range(19) == 0)
                break;
            if (b == CH_STAR)
            begin
                repeat ($urandom_range(3))
                begin
                    path_byte(path_char());
                    emitted++;
                end
            end
            else if (!(i == n - 1 && b == CH_DOLLAR))
            begin
                path_byte(($urandom_range(19) == 0) ? path_char() : b);
                emitted++;
            end
        end
        if ($urandom_range(9) < 4)
            repeat ($urandom_range(1, 3))
                path_byte(path_char());
        end_path();
    endtask

    task automatic run_episode();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30)
            repeat ($urandom_range(1, 3))
                program_rule($urandom_range(NUM_RULES_DEF - 1));
        else if (roll < 35)
            table_noise();
        roll = $urandom_range(99);
        if (roll < 80)
            walk_path($urandom_range(NUM_RULES_DEF - 1));
        else if (roll < 90)
            end_path();
        else
        begin
            repeat ($urandom_range(1, 10))
                path_byte(CHAR_W'($urandom_range(255)));
            end_path();
        end
    endtask

    task automatic directed_items();
        // Empty table and empty path.
        end_path();
        // A pattern of only '$' matches the empty path and nothing else.
        put_byte(7, 0, CH_DOLLAR);
        put_header(7, KIND_DISALLOW, 1);
        end_path();
        feed_byte(8'h00);
        end_path();
        // A '$' in the middle is a plain byte; the table changes mid-path.
        put_byte(0, 0, "a");
        put_byte(0, 1, CH_DOLLAR);
        put_byte(0, 2, "b");
        put_header(0, KIND_ALLOW, 3);
        feed_byte("a");
        put_byte(3, 0, "a");
        put_header(3, KIND_DISALLOW, 1);
        feed_byte(CH_DOLLAR);
        feed_byte("b");
        end_path();
        // Field extremes; the odd header is replaced before anything reads it.
        put_byte(2, PAT_LEN_DEF - 1, 8'hFF);
        send_item(MODE_HDR, SLOT_W'(1), KIND_W'(3), LEN_W'(63), '0, '0);
        send_item(MODE_HDR, SLOT_W'(1), KIND_UNUSED, '0, '1, '1);
        feed_byte(8'hFF);
        end_path();
    endtask

    initial
    begin
        int idle_plan [4];
        int stall_plan [4];
        int target;
        idle_plan = '{0, 77, 0, 15};
        stall_plan = '{0, 0, 77, 15};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_items();
        for (int s = 0; s < NUM_RULES_DEF; s++)
            program_rule(s);
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = idle_plan[ph];
            stall_pct <= stall_plan[ph];
            target = items_sent + 450;
            while (items_sent < target)
            begin
                run_episode();
                if ($urandom_range(49) == 0)
                    wait_drained();
            end
            wait_drained();
        end
        stall_pct <= 0;
        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
